@@ rtl/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, codes and constants of the 1-wire ROM reader.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // rom read length, default for the top level parameter
  localparam int ROM_BYTES_DEF = 8;

  // entries of the queue between front and engine, a power of two
  localparam int QUEUE_DEPTH = 2;

  // command codes on the op field
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_RESET = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_ROM   = 3'd4;

  // line drive codes
  localparam logic [1:0] DRIVE_FLOAT = 2'd0;
  localparam logic [1:0] DRIVE_LOW   = 2'd1;
  localparam logic [1:0] DRIVE_HIGH  = 2'd2;

  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [7:0] READ_ROM_CMD = 8'h33;

  localparam logic [15:0] RESET_LOW_DEF     = 16'd500;
  localparam logic [15:0] RESET_RELEASE_DEF = 16'd500;
  localparam logic [7:0]  SLOT_LOW_DEF      = 8'd2;
  localparam logic [7:0]  WRITE_HOLD_DEF    = 8'd60;
  localparam logic [7:0]  WRITE_REC_DEF     = 8'd2;
  localparam logic [7:0]  READ_SETTLE_DEF   = 8'd8;
  localparam logic [7:0]  READ_WAIT_DEF     = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_RESET_RELEASE = 3'd1,
    CFG_SLOT_LOW      = 3'd2,
    CFG_WRITE_HOLD    = 3'd3,
    CFG_WRITE_REC     = 3'd4,
    CFG_READ_SETTLE   = 3'd5,
    CFG_READ_WAIT     = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ,
    CMD_ROM
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REL,
    PH_W_LOW,
    PH_W_HOLD,
    PH_W_REC,
    PH_R_LOW,
    PH_R_SETTLE,
    PH_R_WAIT
  } phase_t;

  typedef struct packed {
    logic [15:0] reset_low;
    logic [15:0] reset_release;
    logic [7:0]  slot_low;
    logic [7:0]  write_hold;
    logic [7:0]  write_rec;
    logic [7:0]  read_settle;
    logic [7:0]  read_wait;
  } timing_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       line_in;
  } queue_item_t;

  typedef struct packed {
    logic [1:0] line_drive;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic [2:0] byte_index;
    logic       done_res;
    logic       crc_ok;
  } result_t;

  // one bit of the reflected crc-8
  function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
    logic [7:0] s;
    s = {1'b0, crc[7:1]};
    if (crc[0] ^ b) begin
      s = s ^ CRC_POLY;
    end
    return s;
  endfunction

endpackage

@@ rtl/owm_if.sv @@
// ----------------------------------------------------------------------------
// owm channel interfaces
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface owm_in_if;
  logic                       valid;
  logic                       ready;
  logic [owm_pkg::OP_W-1:0]   op;
  logic [7:0]                 tx_byte;
  logic                       line_in;

  modport source (output valid, op, tx_byte, line_in, input ready);
  modport sink   (input valid, op, tx_byte, line_in, output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] line_drive;
  logic       busy_res;
  logic       byte_valid;
  logic [7:0] rx_byte;
  logic [2:0] byte_index;
  logic       done_res;
  logic       crc_ok;

  modport source (output valid, line_drive, busy_res, byte_valid, rx_byte, byte_index,
                  done_res, crc_ok, input ready);
  modport sink   (input valid, line_drive, busy_res, byte_valid, rx_byte, byte_index,
                  done_res, crc_ok, output ready);
endinterface

interface owm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [owm_pkg::CFG_IDX_W-1:0]      index;
  logic [owm_pkg::CFG_DAT_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/onewire_master_rom_reader.sv @@
// ----------------------------------------------------------------------------
// onewire_master_rom_reader
// 1-wire bus master with reset, byte write, byte read and rom read with crc.
// ----------------------------------------------------------------------------
// Each item is one microsecond tick carrying the sampled line and an optional
// command, and yields exactly one result item telling how to drive the line.
// The block takes one item per clock cycle while no result waits on a stalled
// output, since a tick only steps the slot counter and the phase machine. An
// accepted item is held in the queue, and its result is then registered in the
// engine's output register. A two-entry queue sits between the decoding front
// and the slot engine, so up to two more items are taken while a result waits.
// Timing registers are written through the configuration channel; the user
// must write them only while no command is running; the block does not enforce it.
module onewire_master_rom_reader #(
  parameter int ROM_BYTES = owm_pkg::ROM_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  owm_in_if.sink     in_ch,
  owm_out_if.source  out_ch,
  owm_cfg_if.sink    cfg_ch
);
  import owm_pkg::*;

  timing_t     timing_r;
  queue_item_t push_item;
  queue_item_t pop_item;
  result_t     res;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  logic        res_valid;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.reset_low     <= RESET_LOW_DEF;
      timing_r.reset_release <= RESET_RELEASE_DEF;
      timing_r.slot_low      <= SLOT_LOW_DEF;
      timing_r.write_hold    <= WRITE_HOLD_DEF;
      timing_r.write_rec     <= WRITE_REC_DEF;
      timing_r.read_settle   <= READ_SETTLE_DEF;
      timing_r.read_wait     <= READ_WAIT_DEF;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_RESET_LOW:     timing_r.reset_low     <= cfg_ch.data;
        CFG_RESET_RELEASE: timing_r.reset_release <= cfg_ch.data;
        CFG_SLOT_LOW:      timing_r.slot_low      <= cfg_ch.data[7:0];
        CFG_WRITE_HOLD:    timing_r.write_hold    <= cfg_ch.data[7:0];
        CFG_WRITE_REC:     timing_r.write_rec     <= cfg_ch.data[7:0];
        CFG_READ_SETTLE:   timing_r.read_settle   <= cfg_ch.data[7:0];
        CFG_READ_WAIT:     timing_r.read_wait     <= cfg_ch.data[7:0];
        default: ; // writes past the register list are dropped
      endcase
    end
  end

  owm_front u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (in_ch.op),
    .in_tx_byte (in_ch.tx_byte),
    .in_line_in (in_ch.line_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  owm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  owm_engine #(
    .ROM_BYTES (ROM_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .timing    (timing_r),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.valid      = res_valid;
  assign out_ch.line_drive = res.line_drive;
  assign out_ch.busy_res   = res.busy_res;
  assign out_ch.byte_valid = res.byte_valid;
  assign out_ch.rx_byte    = res.rx_byte;
  assign out_ch.byte_index = res.byte_index;
  assign out_ch.done_res   = res.done_res;
  assign out_ch.crc_ok     = res.crc_ok;

endmodule

@@ rtl/owm_front.sv @@
// ----------------------------------------------------------------------------
// owm_front
// Takes tick items and turns the op field into a command class for the queue.
// ----------------------------------------------------------------------------
module owm_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [owm_pkg::OP_W-1:0]  in_op,
  input  logic [7:0]                in_tx_byte,
  input  logic                      in_line_in,
  input  logic                      q_full,
  output logic                      q_push,
  output owm_pkg::queue_item_t      q_item
);
  import owm_pkg::*;

  cmd_t cmd;

  always_comb begin
    unique case (in_op)
      OP_RESET: cmd = CMD_RESET;
      OP_WRITE: cmd = CMD_WRITE;
      OP_READ:  cmd = CMD_READ;
      OP_ROM:   cmd = CMD_ROM;
      default:  cmd = CMD_NONE; // plain tick and unused codes
    endcase
  end

  assign in_ready       = !q_full;
  assign q_push         = in_valid && !q_full;
  assign q_item.cmd     = cmd;
  assign q_item.tx_byte = in_tx_byte;
  assign q_item.line_in = in_line_in;

endmodule

@@ rtl/owm_queue.sv @@
// ----------------------------------------------------------------------------
// owm_queue
// Short fifo between the front and the engine.
// ----------------------------------------------------------------------------
module owm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  owm_pkg::queue_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output owm_pkg::queue_item_t pop_item,
  output logic                 empty
);
  import owm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  queue_item_t      mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full     = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/owm_engine.sv @@
// ----------------------------------------------------------------------------
// owm_engine
// Slot sequencer: steps the bus phase once per tick and registers the result.
// ----------------------------------------------------------------------------
module owm_engine #(
  parameter int ROM_BYTES = owm_pkg::ROM_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  owm_pkg::timing_t     timing,
  input  logic                 q_empty,
  input  owm_pkg::queue_item_t q_item,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output owm_pkg::result_t     res
);
  import owm_pkg::*;

  phase_t      phase_r,  phase_nxt;
  logic [15:0] tick_r,   tick_nxt;
  logic [2:0]  bit_r,    bit_nxt;
  logic [2:0]  byte_r,   byte_nxt;
  logic [7:0]  shift_r,  shift_nxt;
  logic        rom_r,    rom_nxt;
  logic [7:0]  crc_r,    crc_nxt;
  result_t     res_r,    res_nxt;
  logic        valid_r;

  logic [15:0] dur;
  logic        last_tick;
  logic        last_byte;

  assign q_pop     = !q_empty && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    rom_nxt   = rom_r;
    crc_nxt   = crc_r;
    res_nxt   = '0;
    dur       = 16'd1;
    last_tick = 1'b0;
    last_byte = 1'b0;

    // command start: the accepting tick is the first tick of the first phase
    if (phase_r == PH_IDLE && q_item.cmd != CMD_NONE) begin
      rom_nxt  = (q_item.cmd == CMD_ROM);
      tick_nxt = '0;
      bit_nxt  = '0;
      byte_nxt = '0;
      unique case (q_item.cmd)
        CMD_RESET: phase_nxt = PH_RST_LOW;
        CMD_WRITE: begin
          shift_nxt = q_item.tx_byte;
          phase_nxt = PH_W_LOW;
        end
        CMD_ROM: begin
          shift_nxt = READ_ROM_CMD;
          phase_nxt = PH_W_LOW;
        end
        CMD_READ:  phase_nxt = PH_R_LOW;
        default:   phase_nxt = PH_IDLE;
      endcase
    end

    if (phase_nxt != PH_IDLE) begin
      res_nxt.busy_res = 1'b1;
      unique case (phase_nxt)
        PH_RST_LOW: begin
          res_nxt.line_drive = DRIVE_LOW;
          dur = timing.reset_low;
        end
        PH_RST_REL: begin
          res_nxt.line_drive = DRIVE_FLOAT;
          dur = timing.reset_release;
        end
        PH_W_LOW, PH_R_LOW: begin
          res_nxt.line_drive = DRIVE_LOW;
          dur = {8'h00, timing.slot_low};
        end
        PH_W_HOLD: begin
          res_nxt.line_drive = shift_nxt[0] ? DRIVE_HIGH : DRIVE_LOW;
          dur = {8'h00, timing.write_hold};
        end
        PH_W_REC: begin
          res_nxt.line_drive = DRIVE_FLOAT;
          dur = {8'h00, timing.write_rec};
        end
        PH_R_SETTLE: begin
          res_nxt.line_drive = DRIVE_FLOAT;
          dur = {8'h00, timing.read_settle};
        end
        default: begin
          res_nxt.line_drive = DRIVE_FLOAT;
          dur = {8'h00, timing.read_wait};
        end
      endcase

      // sample on the first tick of the wait phase
      if (phase_nxt == PH_R_WAIT && tick_nxt == '0) begin
        shift_nxt = {q_item.line_in, shift_nxt[7:1]};
        if (rom_nxt) begin
          crc_nxt = crc8_bit(crc_nxt, q_item.line_in);
        end
      end

      // a zero duration acts as one tick
      last_tick = ({1'b0, tick_nxt} + 17'd1) >= {1'b0, dur};
      last_byte = ({1'b0, byte_nxt} + 4'd1) >= 4'(ROM_BYTES);

      if (last_tick) begin
        tick_nxt = '0;
        unique case (phase_nxt)
          PH_RST_LOW: phase_nxt = PH_RST_REL;
          PH_RST_REL: begin
            phase_nxt        = PH_IDLE;
            res_nxt.done_res = 1'b1;
          end
          PH_W_LOW:   phase_nxt = PH_W_HOLD;
          PH_W_HOLD:  phase_nxt = PH_W_REC;
          PH_W_REC: begin
            shift_nxt = {1'b0, shift_nxt[7:1]};
            if (bit_nxt != 3'd7) begin
              bit_nxt   = bit_nxt + 3'd1;
              phase_nxt = PH_W_LOW;
            end else if (rom_nxt) begin
              // command byte sent, go read the rom bytes
              bit_nxt   = '0;
              byte_nxt  = '0;
              crc_nxt   = '0;
              shift_nxt = '0;
              phase_nxt = PH_R_LOW;
            end else begin
              bit_nxt          = '0;
              phase_nxt        = PH_IDLE;
              res_nxt.done_res = 1'b1;
            end
          end
          PH_R_LOW:    phase_nxt = PH_R_SETTLE;
          PH_R_SETTLE: phase_nxt = PH_R_WAIT;
          default: begin
            if (bit_nxt != 3'd7) begin
              bit_nxt   = bit_nxt + 3'd1;
              phase_nxt = PH_R_LOW;
            end else begin
              bit_nxt            = '0;
              res_nxt.byte_valid = 1'b1;
              res_nxt.rx_byte    = shift_nxt;
              if (rom_nxt) begin
                res_nxt.byte_index = byte_nxt;
                if (last_byte) begin
                  phase_nxt        = PH_IDLE;
                  res_nxt.done_res = 1'b1;
                  res_nxt.crc_ok   = (crc_nxt == 8'h00);
                end else begin
                  byte_nxt  = byte_nxt + 3'd1;
                  phase_nxt = PH_R_LOW;
                end
              end else begin
                phase_nxt        = PH_IDLE;
                res_nxt.done_res = 1'b1;
              end
            end
          end
        endcase
      end else begin
        tick_nxt = tick_nxt + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      byte_r  <= '0;
      shift_r <= '0;
      rom_r   <= 1'b0;
      crc_r   <= '0;
      valid_r <= 1'b0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      rom_r   <= rom_nxt;
      crc_r   <= crc_nxt;
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ rtl/owm_checker.sv @@
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks of the rom reader, bound to the top level.
// ----------------------------------------------------------------------------
module owm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_line_drive,
  input logic       out_busy_res,
  input logic       out_byte_valid,
  input logic [7:0] out_rx_byte,
  input logic [2:0] out_byte_index,
  input logic       out_done_res,
  input logic       out_crc_ok
);
  import owm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rx_byte) &&
    $stable(out_line_drive) && $stable(out_done_res))
    else $error("result changed while stalled");

  a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_rx_byte == 8'h00 && out_byte_index == 3'd0)
    else $error("byte fields set without a byte");

  a_crc_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crc_ok |-> out_done_res && out_byte_valid)
    else $error("crc_ok outside the last rom byte");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_done_res || out_line_drive != DRIVE_FLOAT) |-> out_busy_res)
    else $error("activity reported while idle");

  a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_drive == DRIVE_FLOAT || out_line_drive == DRIVE_LOW ||
    out_line_drive == DRIVE_HIGH)
    else $error("bad line drive code");

endmodule

bind onewire_master_rom_reader owm_checker u_owm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_line_drive (out_ch.line_drive),
  .out_busy_res   (out_ch.busy_res),
  .out_byte_valid (out_ch.byte_valid),
  .out_rx_byte    (out_ch.rx_byte),
  .out_byte_index (out_ch.byte_index),
  .out_done_res   (out_ch.done_res),
  .out_crc_ok     (out_ch.crc_ok)
);
